### rtl/susp_pkg.sv
// ----------------------------------------------------------------------------
// susp_pkg: shared types and constants of the size unit string parser
// Parse phase codes, status codes, character codes and the parser state
// record that the step logic and the top level both use.
// ----------------------------------------------------------------------------
`default_nettype none

package susp_pkg;

    localparam int PhaseW = 3;

    // parse phases
    localparam logic [PhaseW-1:0] PH_SKIP = 3'd0;  // expect number or space
    localparam logic [PhaseW-1:0] PH_DIG  = 3'd1;  // inside a number
    localparam logic [PhaseW-1:0] PH_GAP  = 3'd2;  // space after a number
    localparam logic [PhaseW-1:0] PH_P    = 3'd3;  // seen 'p'
    localparam logic [PhaseW-1:0] PH_PA   = 3'd4;  // seen "pa"
    localparam logic [PhaseW-1:0] PH_A    = 3'd5;  // seen 'a'
    localparam logic [PhaseW-1:0] PH_AS   = 3'd6;  // seen "as"

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_DUP      = 2'd2;
    localparam logic [1:0] ST_BAD_UNIT = 2'd3;

    // field selects
    localparam logic [1:0] UNIT_PX  = 2'd0;
    localparam logic [1:0] UNIT_PAD = 2'd1;
    localparam logic [1:0] UNIT_ASC = 2'd2;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_X     = 8'h78;

    localparam logic [16:0] U16_MAX = 17'd65535;
    localparam logic [16:0] U8_MAX  = 17'd255;
    localparam logic [16:0] ACC_SAT = 17'd65536;

    typedef struct packed {
        logic [PhaseW-1:0] phase;
        logic [16:0]       acc;
        logic [15:0]       px;
        logic [7:0]        pad;
        logic [7:0]        asc;
        logic [1:0]        err;
        logic              ended;
    } parse_state_t;

    localparam parse_state_t STATE_INIT = '{
        phase: PH_SKIP,
        acc:   17'd0,
        px:    16'd0,
        pad:   8'd0,
        asc:   8'd0,
        err:   ST_OK,
        ended: 1'b0
    };

endpackage

`default_nettype wire

### rtl/size_unit_string_parser_top.sv
// ----------------------------------------------------------------------------
// size_unit_string_parser_top: streaming size string parser
// Parses "<num>[px|pad|asc] ..." one byte per transfer into a pixel size,
// a padding count and an ascent count plus a status code.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in      | into      | in_valid / in_stall     | char_byte, last_byte
//  out     | out of    | out_valid / out_stall   | px_size, pad_count,
//          |           |                         | asc_count, status
//
// one byte per cycle while no final byte waits for the result register; the
// byte is held in the input register and its state update is done in the
// cycle it leaves that register, which for a final byte also loads the result
// the parser state returns to its initial value after each final byte
// rst_n clears the input and result valid flags and the parser state
// a stalled result only holds back a final byte; other bytes keep flowing
// ----------------------------------------------------------------------------
`default_nettype none

module size_unit_string_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] px_size,
    output logic [7:0]  pad_count,
    output logic [7:0]  asc_count,
    output logic [1:0]  status
);
    import susp_pkg::*;

    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   char_reg;
    logic         last_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic [15:0]  px_reg;
    logic [7:0]   pad_reg;
    logic [7:0]   asc_reg;
    logic [1:0]   status_reg;
    logic [15:0]  px_next;
    logic [7:0]   pad_next;
    logic [7:0]   asc_next;
    logic [1:0]   status_next;
    logic         out_free;
    logic         proc_fire;
    logic         in_xfer;

    susp_step u_step (
        .cur       (state_reg),
        .char_byte (char_reg),
        .last_byte (last_reg),
        .nxt       (state_next),
        .px_size   (px_next),
        .pad_count (pad_next),
        .asc_count (asc_next),
        .status    (status_next)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    // only a final byte needs room in the result register
    assign proc_fire = in_valid_reg && (!last_reg || out_free);
    assign in_stall  = in_valid_reg && !proc_fire;
    assign in_xfer   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xfer)
            in_valid_next = 1'b1;
        else if (proc_fire)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (proc_fire && last_reg)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_INIT;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (proc_fire)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            char_reg <= char_byte;
            last_reg <= last_byte;
        end
        if (proc_fire && last_reg)
        begin
            px_reg     <= px_next;
            pad_reg    <= pad_next;
            asc_reg    <= asc_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign px_size   = px_reg;
    assign pad_count = pad_reg;
    assign asc_count = asc_reg;
    assign status    = status_reg;

    // a result only shows up after a final byte was processed
    a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(proc_fire && last_reg))
        else $error("result without a final byte");

    // the parser restarts after every final byte
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && last_reg) |=> (state_reg == STATE_INIT))
        else $error("parser state not cleared after final byte");

    // an error sticks until the string is closed
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.err != ST_OK && !(proc_fire && last_reg))
        |=> (state_reg.err == $past(state_reg.err)))
        else $error("error code changed inside a string");

    // the input side only stalls while a final byte waits for the result slot
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && last_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

### rtl/susp_step.sv
// ----------------------------------------------------------------------------
// susp_step: next-state logic for one string byte
// Takes the current parser state and one byte, gives the state after it and,
// for the final byte, the fields of the result.
// ----------------------------------------------------------------------------
`default_nettype none

module susp_step (
    input  susp_pkg::parse_state_t cur,
    input  logic [7:0]             char_byte,
    input  logic                   last_byte,
    output susp_pkg::parse_state_t nxt,
    output logic [15:0]            px_size,
    output logic [7:0]             pad_count,
    output logic [7:0]             asc_count,
    output logic [1:0]             status
);
    import susp_pkg::*;

    function automatic parse_state_t apply_unit(parse_state_t s, logic [1:0] unit);
        parse_state_t r;
        r = s;
        case (unit)
            UNIT_PX:
            begin
                if (s.acc > U16_MAX)
                    r.err = ST_OVERFLOW;
                else if (s.px != 16'd0)
                    r.err = ST_DUP;
                else
                    r.px = s.acc[15:0];
            end
            UNIT_PAD:
            begin
                if (s.acc > U8_MAX)
                    r.err = ST_OVERFLOW;
                else if (s.pad != 8'd0)
                    r.err = ST_DUP;
                else
                    r.pad = s.acc[7:0];
            end
            default:
            begin
                if (s.acc > U8_MAX)
                    r.err = ST_OVERFLOW;
                else if (s.asc != 8'd0)
                    r.err = ST_DUP;
                else
                    r.asc = s.acc[7:0];
            end
        endcase
        if (r.err == ST_OK)
        begin
            r.acc   = 17'd0;
            r.phase = PH_SKIP;
        end
        return r;
    endfunction

    function automatic parse_state_t unit_start(parse_state_t s, logic [7:0] c);
        parse_state_t r;
        r = s;
        if (c == CH_P)
            r.phase = PH_P;
        else if (c == CH_A)
            r.phase = PH_A;
        else
            r.err = ST_BAD_UNIT;
        return r;
    endfunction

    function automatic parse_state_t finish(parse_state_t s);
        parse_state_t r;
        r = s;
        if (s.phase == PH_DIG || s.phase == PH_GAP)
            r = apply_unit(s, UNIT_PX);
        else if (s.phase != PH_SKIP)
            r.err = ST_BAD_UNIT;
        r.ended = 1'b1;
        return r;
    endfunction

    logic        is_ws;
    logic        is_digit;
    logic [16:0] digit_val;
    logic [19:0] acc_x10;
    parse_state_t s1;
    parse_state_t s2;
    parse_state_t gap_px;

    assign is_ws     = (char_byte == CH_SPACE) ||
                       (char_byte >= CH_TAB && char_byte <= CH_CR);
    assign is_digit  = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
    assign digit_val = {9'd0, char_byte - CH_ZERO};
    // acc * 10 + digit as shifts and adds
    assign acc_x10   = {cur.acc, 3'd0} + {2'd0, cur.acc, 1'b0} + {3'd0, digit_val};
    assign gap_px    = apply_unit(cur, UNIT_PX);

    always_comb
    begin
        s1 = cur;
        if (!cur.ended && cur.err == ST_OK)
        begin
            if (char_byte == CH_NUL)
            begin
                s1 = finish(cur);
            end
            else
            begin
                case (cur.phase)
                    PH_SKIP:
                    begin
                        if (is_digit)
                        begin
                            s1.acc   = digit_val;
                            s1.phase = PH_DIG;
                        end
                        else if (!is_ws)
                        begin
                            s1.acc = 17'd0;
                            s1     = unit_start(s1, char_byte);
                        end
                    end
                    PH_DIG:
                    begin
                        if (is_digit)
                            s1.acc = (acc_x10 > {3'd0, U16_MAX}) ? ACC_SAT : acc_x10[16:0];
                        else if (is_ws)
                            s1.phase = PH_GAP;
                        else
                            s1 = unit_start(cur, char_byte);
                    end
                    PH_GAP:
                    begin
                        if (is_digit)
                        begin
                            s1 = gap_px;
                            if (gap_px.err == ST_OK)
                            begin
                                s1.acc   = digit_val;
                                s1.phase = PH_DIG;
                            end
                        end
                        else if (!is_ws)
                        begin
                            s1 = unit_start(cur, char_byte);
                        end
                    end
                    PH_P:
                    begin
                        if (char_byte == CH_X)
                            s1 = apply_unit(cur, UNIT_PX);
                        else if (char_byte == CH_A)
                            s1.phase = PH_PA;
                        else
                            s1.err = ST_BAD_UNIT;
                    end
                    PH_PA:
                    begin
                        if (char_byte == CH_D)
                            s1 = apply_unit(cur, UNIT_PAD);
                        else
                            s1.err = ST_BAD_UNIT;
                    end
                    PH_A:
                    begin
                        if (char_byte == CH_S)
                            s1.phase = PH_AS;
                        else
                            s1.err = ST_BAD_UNIT;
                    end
                    PH_AS:
                    begin
                        if (char_byte == CH_C)
                            s1 = apply_unit(cur, UNIT_ASC);
                        else
                            s1.err = ST_BAD_UNIT;
                    end
                    default:
                    begin
                        s1.err = ST_BAD_UNIT;
                    end
                endcase
            end
        end
    end

    // close the string on the final byte
    always_comb
    begin
        s2 = s1;
        if (!s1.ended && s1.err == ST_OK)
            s2 = finish(s1);
    end

    assign px_size   = s2.px;
    assign pad_count = s2.pad;
    assign asc_count = s2.asc;
    assign status    = s2.err;
    assign nxt       = last_byte ? STATE_INIT : s1;

endmodule

`default_nettype wire
